@@ design/midi_track_event_encoder_macros.svh @@
// assertion macros used by the top-level encoder design file
`ifndef MIDI_TRACK_EVENT_ENCODER_MACROS_SVH
`define MIDI_TRACK_EVENT_ENCODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define MTE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed on same-cycle check");

// next-cycle implication, checked outside reset
`define MTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed on next-cycle check");

`endif

@@ design/mte_pkg.sv @@
package mte_pkg;

  // frame geometry
  localparam int unsigned FRAME_BYTES = 7;
  localparam int unsigned IDX_W       = 3;

  // action codes
  localparam logic ACT_EVENT = 1'b0;
  localparam logic ACT_EOT   = 1'b1;

  // status nibbles
  localparam logic [3:0] TYPE_FIRST_VALID = 4'h8;
  localparam logic [3:0] TYPE_LAST_VALID  = 4'hE;
  localparam logic [3:0] TYPE_PROGRAM     = 4'hC;
  localparam logic [3:0] TYPE_AFTERTOUCH  = 4'hD;

  // stream bytes
  localparam logic [7:0] VLQ_CONT  = 8'h80;
  localparam logic [7:0] META_BYTE = 8'hFF;
  localparam logic [7:0] EOT_BYTE  = 8'h2F;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  typedef struct packed {
    logic        action;
    logic [31:0] event_tick;
    logic [3:0]  event_type;
    logic [3:0]  channel;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic       error_flag;
  } out_item_t;

  typedef struct packed {
    logic [FRAME_BYTES-1:0][7:0] bytes;
    logic [IDX_W-1:0]            last_idx;
    logic                        err;
  } frame_t;

  typedef struct packed {
    logic busy;
    logic ready;
  } ser_status_t;

endpackage

@@ design/mte_framer.sv @@
module mte_framer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  mte_pkg::in_item_t item_i,
  output mte_pkg::frame_t   frame_o
);
  import mte_pkg::*;

  logic [31:0] prev_tick_q, prev_tick_d;
  logic [31:0] delta;
  logic        too_big;
  logic        bad_type;
  logic [1:0]  nb;
  logic [7:0]  vlq3, vlq2, vlq1, vlq0;
  logic [7:0]  status_byte, second_byte;

  // delta against the stored tick and range checks
  assign delta    = item_i.event_tick - prev_tick_q;
  assign too_big  = |delta[31:28];
  assign bad_type = (item_i.event_type < TYPE_FIRST_VALID) ||
                    (item_i.event_type > TYPE_LAST_VALID);

  // number of extra vlq groups
  always_comb begin
    if (|delta[27:21]) begin
      nb = 2'd3;
    end else if (|delta[20:14]) begin
      nb = 2'd2;
    end else if (|delta[13:7]) begin
      nb = 2'd1;
    end else begin
      nb = 2'd0;
    end
  end

  assign vlq3 = VLQ_CONT | {1'b0, delta[27:21]};
  assign vlq2 = VLQ_CONT | {1'b0, delta[20:14]};
  assign vlq1 = VLQ_CONT | {1'b0, delta[13:7]};
  assign vlq0 = {1'b0, delta[6:0]};

  assign status_byte = {item_i.event_type, item_i.channel};
  assign second_byte = ((item_i.event_type == TYPE_PROGRAM) ||
                        (item_i.event_type == TYPE_AFTERTOUCH)) ?
                       ZERO_BYTE : item_i.data_second;

  // frame assembly
  always_comb begin
    frame_o = '0;
    if (item_i.action == ACT_EOT) begin
      frame_o.bytes[0] = ZERO_BYTE;
      frame_o.bytes[1] = META_BYTE;
      frame_o.bytes[2] = EOT_BYTE;
      frame_o.bytes[3] = ZERO_BYTE;
      frame_o.last_idx = IDX_W'(3);
    end else if (too_big || bad_type) begin
      frame_o.bytes[0] = ZERO_BYTE;
      frame_o.last_idx = '0;
      frame_o.err      = 1'b1;
    end else begin
      case (nb)
        2'd0: begin
          frame_o.bytes[0] = vlq0;
          frame_o.bytes[1] = status_byte;
          frame_o.bytes[2] = item_i.data_first;
          frame_o.bytes[3] = second_byte;
        end
        2'd1: begin
          frame_o.bytes[0] = vlq1;
          frame_o.bytes[1] = vlq0;
          frame_o.bytes[2] = status_byte;
          frame_o.bytes[3] = item_i.data_first;
          frame_o.bytes[4] = second_byte;
        end
        2'd2: begin
          frame_o.bytes[0] = vlq2;
          frame_o.bytes[1] = vlq1;
          frame_o.bytes[2] = vlq0;
          frame_o.bytes[3] = status_byte;
          frame_o.bytes[4] = item_i.data_first;
          frame_o.bytes[5] = second_byte;
        end
        default: begin
          frame_o.bytes[0] = vlq3;
          frame_o.bytes[1] = vlq2;
          frame_o.bytes[2] = vlq1;
          frame_o.bytes[3] = vlq0;
          frame_o.bytes[4] = status_byte;
          frame_o.bytes[5] = item_i.data_first;
          frame_o.bytes[6] = second_byte;
        end
      endcase
      frame_o.last_idx = {1'b0, nb} + IDX_W'(3);
    end
  end

  // previous tick update on accepted transactions; rejected items leave it unchanged
  always_comb begin
    prev_tick_d = prev_tick_q;
    if (accept_i) begin
      if (item_i.action == ACT_EOT) begin
        prev_tick_d = '0;
      end else if (!(too_big || bad_type)) begin
        prev_tick_d = item_i.event_tick;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_tick_q <= '0;
    end else begin
      prev_tick_q <= prev_tick_d;
    end
  end

endmodule

@@ design/mte_serializer.sv @@
module mte_serializer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  mte_pkg::frame_t      frame_i,
  output mte_pkg::ser_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mte_pkg::out_item_t   out_data_o
);
  import mte_pkg::*;

  frame_t           frame_q, frame_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             busy_q, busy_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;
  logic             out_free;
  logic             emit;
  logic             last_emit;

  // byte moves into the output register when it is empty or being drained
  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit      = busy_q && out_free;
  assign last_emit = emit && (idx_q == frame_q.last_idx);

  assign status_o.busy  = busy_q;
  assign status_o.ready = !busy_q || last_emit;

  // frame walk
  always_comb begin
    frame_d = frame_q;
    idx_d   = idx_q;
    busy_d  = busy_q;
    if (load_i) begin
      frame_d = frame_i;
      idx_d   = '0;
      busy_d  = 1'b1;
    end else if (last_emit) begin
      busy_d = 1'b0;
    end else if (emit) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_free) begin
      out_valid_d = emit;
    end
    if (emit) begin
      out_d.out_byte   = frame_q.bytes[idx_q];
      out_d.last_byte  = (idx_q == frame_q.last_idx);
      out_d.error_flag = frame_q.err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ design/midi_track_event_encoder.sv @@
// MIDI track event encoder: timed channel events in, track file bytes out.
// Input channel: in_valid_i / in_stall_o / in_data_i. A transaction carries one
// event or an end-of-track action. Output channel: out_valid_o / out_stall_i /
// out_data_o, one stream byte per transaction, last_byte marks the final byte
// of an input item and error_flag marks the single byte of a rejected item.
// An accepted item is turned combinationally into a whole frame of 4 to 7 bytes,
// or 1 on error, and held in a frame register; a byte walker copies it into the
// output register one byte per cycle while the receiver does not stall. The
// first byte passes the frame register and then the output register on its way
// to out_valid_o. The next item is taken at the edge where the last byte of the
// current frame moves to the output register, so with no stall frames follow
// without a gap and the one-byte-per-cycle output port sets the rate.
// While the receiver stalls, the output register holds its byte, the walker
// waits and in_stall_o rises once the frame register is still in use.
// Reset clears the stored previous tick to zero and drops any partial frame.
module midi_track_event_encoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mte_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mte_pkg::out_item_t out_data_o
);
  import mte_pkg::*;

`include "midi_track_event_encoder_macros.svh"

  frame_t      frame;
  ser_status_t ser_status;
  logic        in_accept;

  assign in_stall_o = !ser_status.ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  // frame builder with previous tick
  mte_framer u_framer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_data_i),
    .frame_o  (frame)
  );

  // byte walker and output register
  mte_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_accept),
    .frame_i     (frame),
    .status_o    (ser_status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // checks
  `MTE_ASSERT_NOW(a_err_is_last, clk_i, rst_ni, out_valid_o && out_data_o.error_flag,
                  out_data_o.last_byte && (out_data_o.out_byte == ZERO_BYTE))
  `MTE_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_accept, ser_status.busy)
  `MTE_ASSERT_NEXT(a_frame_gapless, clk_i, rst_ni,
                   out_valid_o && !out_stall_i && !out_data_o.last_byte, out_valid_o)
  `MTE_ASSERT_NOW(a_idle_no_stall, clk_i, rst_ni, !ser_status.busy, !in_stall_o)

endmodule
